/* src/hcbd_pkg.sv */
`timescale 1ns / 1ps
// Package of the chunked body decoder: phase and result codes, byte constants,
// the result struct and the hex digit decoder. Depends on nothing.
package hcbd_pkg;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    K_DATA  = 2'd0,
    K_DONE  = 2'd1,
    K_ERROR = 2'd2
  } kind_e;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

/* src/hcbd_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the chunked body decoder: the raw byte
// channel and the result channel. Depends on nothing.
interface hcbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hcbd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;

  modport source (output valid, output kind, output payload_byte, input ready);
  modport sink (input valid, input kind, input payload_byte, output ready);
endinterface

/* src/hcbd_core.sv */
`timescale 1ns / 1ps
// Decoder state and the per-byte step: size line, data and trailer phases.
// Depends on hcbd_pkg.
module hcbd_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output hcbd_pkg::result_t result_o
);

  hcbd_pkg::phase_e       phase_q, phase_d;
  logic [SIZE_BITS-1:0]   accum_q, accum_d;
  logic [SIZE_BITS-1:0]   left_q, left_d;
  logic [SIZE_BITS-1:0]   left_dec;
  logic                   digits_done_q, digits_done_d;
  logic                   line_started_q, line_started_d;
  logic                   overflow_q, overflow_d;
  logic                   prev_lf_q, prev_lf_d;
  hcbd_pkg::hex_digit_t   digit;

  assign digit    = hcbd_pkg::hex_decode(byte_i);
  assign left_dec = left_q - SIZE_BITS'(1);

  always_comb begin
    phase_d        = phase_q;
    accum_d        = accum_q;
    left_d         = left_q;
    digits_done_d  = digits_done_q;
    line_started_d = line_started_q;
    overflow_d     = overflow_q;
    prev_lf_d      = prev_lf_q;
    result_o.valid        = 1'b0;
    result_o.kind         = hcbd_pkg::K_DATA;
    result_o.payload_byte = 8'd0;

    unique case (phase_q)
      hcbd_pkg::PH_DATA: begin
        left_d                = left_dec;
        result_o.valid        = 1'b1;
        result_o.payload_byte = byte_i;
        if (left_dec == '0) begin
          phase_d = hcbd_pkg::PH_SIZE;
        end
      end
      hcbd_pkg::PH_TRAILER: begin
        if (prev_lf_q && byte_i == hcbd_pkg::CHAR_CR) begin
          phase_d        = hcbd_pkg::PH_SIZE;
          prev_lf_d      = 1'b0;
          result_o.valid = 1'b1;
          result_o.kind  = hcbd_pkg::K_DONE;
        end else begin
          prev_lf_d = (byte_i == hcbd_pkg::CHAR_LF);
        end
      end
      default: begin
        // Size line; the unused phase code behaves the same way.
        if (!line_started_q && (byte_i == hcbd_pkg::CHAR_CR ||
            byte_i == hcbd_pkg::CHAR_LF || byte_i == hcbd_pkg::CHAR_SP)) begin
          phase_d = phase_q;
        end else if (byte_i == hcbd_pkg::CHAR_LF) begin
          accum_d        = '0;
          left_d         = '0;
          digits_done_d  = 1'b0;
          line_started_d = 1'b0;
          overflow_d     = 1'b0;
          prev_lf_d      = 1'b0;
          phase_d        = hcbd_pkg::PH_SIZE;
          if (overflow_q) begin
            result_o.valid = 1'b1;
            result_o.kind  = hcbd_pkg::K_ERROR;
          end else if (accum_q == '0) begin
            phase_d   = hcbd_pkg::PH_TRAILER;
            prev_lf_d = 1'b1;
          end else begin
            phase_d = hcbd_pkg::PH_DATA;
            left_d  = accum_q;
          end
        end else begin
          line_started_d = 1'b1;
          if (!digits_done_q) begin
            if (!digit.is_hex) begin
              digits_done_d = 1'b1;
            end else if (!overflow_q) begin
              if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                overflow_d = 1'b1;
              end else begin
                accum_d = {accum_q[SIZE_BITS-5:0], digit.value};
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= hcbd_pkg::PH_SIZE;
      accum_q        <= '0;
      left_q         <= '0;
      digits_done_q  <= 1'b0;
      line_started_q <= 1'b0;
      overflow_q     <= 1'b0;
      prev_lf_q      <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      accum_q        <= accum_d;
      left_q         <= left_d;
      digits_done_q  <= digits_done_d;
      line_started_q <= line_started_d;
      overflow_q     <= overflow_d;
      prev_lf_q      <= prev_lf_d;
    end
  end

endmodule

/* src/http_chunked_body_decoder_unit.sv */
`timescale 1ns / 1ps
// Top level of the HTTP chunked body decoder: input register, decoder core and
// result register. Depends on hcbd_pkg, hcbd_stream_if and hcbd_core.
//
// The in_i channel carries one raw byte of a chunked message body per word.
// The out_o channel carries the results: a payload data byte (kind 0), body
// complete (kind 1) or size line error (kind 2). Only data bytes, the LF that
// ends an overflowed size line and the CR ending the trailer give a result.
// A byte accepted into the input register is decoded by the core once the
// result register is free, and its result word is then written into the
// result register. One byte per cycle is accepted as long as the
// result register is empty or is being read in the same cycle.
// When the receiver holds ready low, the result word waits in the result
// register, the byte behind it waits in the input register, and in_i.ready
// drops until the result register frees up.
// Reset clears the valid flags and puts the decoder at the start of a fresh
// size line, ready for a new body; no clearing pass is needed.
module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hcbd_byte_if.sink     in_i,
  hcbd_result_if.source out_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  hcbd_pkg::kind_e   kind_q;
  logic [7:0]        payload_q;
  logic              out_free;
  logic              advance;
  hcbd_pkg::result_t step_res;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && step_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_res.valid) begin
      kind_q    <= step_res.kind;
      payload_q <= step_res.payload_byte;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = 2'(kind_q);
  assign out_o.payload_byte = payload_q;

endmodule
